### hw/rtl/segment_intersection_macros.svh
// Assertion macros for the segment intersection block.
// Used by segment_intersection.sv; expects clk and rst_n in scope.
`ifndef SEGMENT_INTERSECTION_MACROS_SVH
`define SEGMENT_INTERSECTION_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define SI_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("segment_intersection: %s failed", "lbl");

// Next-cycle implication checked outside reset.
`define SI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("segment_intersection: %s failed", "lbl");

`endif

### hw/rtl/segint_pkg.sv
// Types and widths for the segment intersection block.
// No dependencies; imported by segment_intersection.sv and test/tb.sv.
package segint_pkg;

  localparam int COORD_WIDTH = 16;
  // direction and offset width
  localparam int DW = COORD_WIDTH + 1;
  // product width
  localparam int MW = 2 * DW;
  // cross-product / numerator width
  localparam int TW = MW + 1;
  // scaled numerator width
  localparam int PW = TW + DW;
  // quotient bits: |quotient| never exceeds a direction component on a hit
  localparam int QB = DW;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] a_start_x;
    logic signed [COORD_WIDTH-1:0] a_start_y;
    logic signed [COORD_WIDTH-1:0] a_end_x;
    logic signed [COORD_WIDTH-1:0] a_end_y;
    logic signed [COORD_WIDTH-1:0] b_start_x;
    logic signed [COORD_WIDTH-1:0] b_start_y;
    logic signed [COORD_WIDTH-1:0] b_end_x;
    logic signed [COORD_WIDTH-1:0] b_end_y;
  } seg_pair_t;

  typedef struct packed {
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] cross_x;
    logic signed [COORD_WIDTH-1:0] cross_y;
  } seg_cross_t;

endpackage

### hw/rtl/segment_intersection.sv
// 2-D segment intersection, fully pipelined.
// Depends on segint_pkg and segment_intersection_macros.svh.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one pair of segments
//   (A and B, signed Q8.8 endpoints) per transfer. Output channel
//   out_valid / out_stall / out_data returns exactly one result per transfer,
//   in order: hit, and the crossing point (zero on a miss).
//   One pair is taken every cycle as long as the receiver takes results.
//   Stages: differences, six 17x17 products, cross products, range test and
//   scaled numerators, magnitudes, then one restoring divider stage per
//   quotient bit for x and y side by side, then the output register.
//   The divider chain, one quotient bit per stage, sets the latency.
//   When the receiver stalls with a result waiting, the whole pipe holds and
//   in_stall rises in the same cycle; nothing is lost or repeated.
//   Reset (rst_n low, synchronous) clears all stage valid bits; data
//   registers are left as they are.
//   Parallel, collinear and zero-length segments give a miss.
module segment_intersection
  import segint_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  seg_pair_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output seg_cross_t out_data
);

`include "segment_intersection_macros.svh"

  localparam int W = COORD_WIDTH;

  // global advance: move every stage when the output slot is free or taken
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // ---- stage 1: differences
  logic                v1_r;
  logic signed [DW-1:0] dax1_r, day1_r, dbx1_r, dby1_r, ox1_r, oy1_r;
  logic signed [W-1:0]  ax1_r, ay1_r;

  // ---- stage 2: products
  logic                v2_r;
  logic signed [MW-1:0] pda2_r, pdb2_r, psa2_r, psb2_r, pta2_r, ptb2_r;
  logic signed [DW-1:0] dax2_r, day2_r;
  logic signed [W-1:0]  ax2_r, ay2_r;

  // ---- stage 3: denominator and numerators
  logic                v3_r;
  logic signed [TW-1:0] den3_r, sn3_r, tn3_r;
  logic signed [DW-1:0] dax3_r, day3_r;
  logic signed [W-1:0]  ax3_r, ay3_r;

  // ---- stage 4: range test and scaled numerators
  logic                v4_r, hit4_r;
  logic signed [PW-1:0] nx4_r, ny4_r;
  logic signed [TW-1:0] den4_r;
  logic signed [W-1:0]  ax4_r, ay4_r;

  // ---- divider chain, entry 0 loaded from magnitudes
  logic          dv_r   [0:QB];
  logic          dhit_r [0:QB];
  logic          dnx_r  [0:QB];
  logic          dny_r  [0:QB];
  logic [PW-1:0] rx_r   [0:QB];
  logic [PW-1:0] ry_r   [0:QB];
  logic [TW-1:0] dd_r   [0:QB];
  logic [QB-1:0] qx_r   [0:QB];
  logic [QB-1:0] qy_r   [0:QB];
  logic [W-1:0]  dax_r  [0:QB];
  logic [W-1:0]  day_r  [0:QB];

  logic [PW-1:0] rx_nxt [0:QB-1];
  logic [PW-1:0] ry_nxt [0:QB-1];
  logic [QB-1:0] qx_nxt [0:QB-1];
  logic [QB-1:0] qy_nxt [0:QB-1];

  // ---- combinational helpers
  logic signed [TW-1:0] den3_nxt, sn3_nxt, tn3_nxt;
  logic                 sn_ok, tn_ok;
  logic signed [TW-1:0] zero_t;
  assign zero_t = '0;

  assign den3_nxt = TW'(pda2_r) - TW'(pdb2_r);
  assign sn3_nxt  = TW'(psa2_r) - TW'(psb2_r);
  assign tn3_nxt  = TW'(pta2_r) - TW'(ptb2_r);

  always_comb begin
    if (den3_r[TW-1]) begin
      sn_ok = (den3_r <= sn3_r) && (sn3_r <= zero_t);
      tn_ok = (den3_r <= tn3_r) && (tn3_r <= zero_t);
    end else begin
      sn_ok = (zero_t <= sn3_r) && (sn3_r <= den3_r);
      tn_ok = (zero_t <= tn3_r) && (tn3_r <= den3_r);
    end
  end

  // one restoring step per stage, most significant quotient bit first
  always_comb begin
    logic [PW:0] sh;
    logic [PW:0] tx;
    logic [PW:0] ty;
    for (int j = 0; j < QB; j++) begin
      sh = (PW + 1)'(dd_r[j]) << (QB - 1 - j);
      tx = {1'b0, rx_r[j]} - sh;
      ty = {1'b0, ry_r[j]} - sh;
      rx_nxt[j] = rx_r[j];
      ry_nxt[j] = ry_r[j];
      qx_nxt[j] = qx_r[j];
      qy_nxt[j] = qy_r[j];
      if (!tx[PW]) begin
        rx_nxt[j]             = tx[PW-1:0];
        qx_nxt[j][QB-1-j]     = 1'b1;
      end
      if (!ty[PW]) begin
        ry_nxt[j]             = ty[PW-1:0];
        qy_nxt[j][QB-1-j]     = 1'b1;
      end
    end
  end

  // final sign fix and offset by segment A start
  logic signed [DW:0] sqx, sqy;
  logic signed [DW:0] px, py;
  assign sqx = dnx_r[QB] ? -$signed({1'b0, qx_r[QB]}) : $signed({1'b0, qx_r[QB]});
  assign sqy = dny_r[QB] ? -$signed({1'b0, qy_r[QB]}) : $signed({1'b0, qy_r[QB]});
  assign px  = (DW + 1)'($signed(dax_r[QB])) + sqx;
  assign py  = (DW + 1)'($signed(day_r[QB])) + sqy;

  // ---- valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      for (int j = 0; j <= QB; j++) dv_r[j] <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1_r      <= in_valid;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      dv_r[0]   <= v4_r;
      for (int j = 0; j < QB; j++) dv_r[j+1] <= dv_r[j];
      out_valid <= dv_r[QB];
    end
  end

  // ---- data path, held when the pipe stalls
  always_ff @(posedge clk) begin
    if (adv) begin
      dax1_r <= DW'(in_data.a_end_x) - DW'(in_data.a_start_x);
      day1_r <= DW'(in_data.a_end_y) - DW'(in_data.a_start_y);
      dbx1_r <= DW'(in_data.b_end_x) - DW'(in_data.b_start_x);
      dby1_r <= DW'(in_data.b_end_y) - DW'(in_data.b_start_y);
      ox1_r  <= DW'(in_data.a_start_x) - DW'(in_data.b_start_x);
      oy1_r  <= DW'(in_data.a_start_y) - DW'(in_data.b_start_y);
      ax1_r  <= in_data.a_start_x;
      ay1_r  <= in_data.a_start_y;

      pda2_r <= MW'(dax1_r) * MW'(dby1_r);
      pdb2_r <= MW'(dbx1_r) * MW'(day1_r);
      psa2_r <= MW'(dax1_r) * MW'(oy1_r);
      psb2_r <= MW'(day1_r) * MW'(ox1_r);
      pta2_r <= MW'(dbx1_r) * MW'(oy1_r);
      ptb2_r <= MW'(dby1_r) * MW'(ox1_r);
      dax2_r <= dax1_r;
      day2_r <= day1_r;
      ax2_r  <= ax1_r;
      ay2_r  <= ay1_r;

      den3_r <= den3_nxt;
      sn3_r  <= sn3_nxt;
      tn3_r  <= tn3_nxt;
      dax3_r <= dax2_r;
      day3_r <= day2_r;
      ax3_r  <= ax2_r;
      ay3_r  <= ay2_r;

      hit4_r <= (den3_r != zero_t) && sn_ok && tn_ok;
      nx4_r  <= PW'(tn3_r) * PW'(dax3_r);
      ny4_r  <= PW'(tn3_r) * PW'(day3_r);
      den4_r <= den3_r;
      ax4_r  <= ax3_r;
      ay4_r  <= ay3_r;

      // magnitudes and result signs
      dhit_r[0] <= hit4_r;
      rx_r[0]   <= nx4_r[PW-1] ? PW'(-nx4_r) : PW'(nx4_r);
      ry_r[0]   <= ny4_r[PW-1] ? PW'(-ny4_r) : PW'(ny4_r);
      dd_r[0]   <= den4_r[TW-1] ? TW'(-den4_r) : TW'(den4_r);
      dnx_r[0]  <= nx4_r[PW-1] ^ den4_r[TW-1];
      dny_r[0]  <= ny4_r[PW-1] ^ den4_r[TW-1];
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
      dax_r[0]  <= ax4_r;
      day_r[0]  <= ay4_r;

      for (int j = 0; j < QB; j++) begin
        dhit_r[j+1] <= dhit_r[j];
        rx_r[j+1]   <= rx_nxt[j];
        ry_r[j+1]   <= ry_nxt[j];
        dd_r[j+1]   <= dd_r[j];
        dnx_r[j+1]  <= dnx_r[j];
        dny_r[j+1]  <= dny_r[j];
        qx_r[j+1]   <= qx_nxt[j];
        qy_r[j+1]   <= qy_nxt[j];
        dax_r[j+1]  <= dax_r[j];
        day_r[j+1]  <= day_r[j];
      end

      out_data.hit     <= dhit_r[QB];
      out_data.cross_x <= dhit_r[QB] ? W'(px) : '0;
      out_data.cross_y <= dhit_r[QB] ? W'(py) : '0;
    end
  end

  // a miss never reports a point
  `SI_ASSERT_IMPL(a_miss_zero, out_valid && !out_data.hit, (out_data.cross_x == '0) && (out_data.cross_y == '0))
  // the input side stalls only behind a waiting, stalled result
  `SI_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall)
  // a zero denominator can never reach the divider as a hit
  `SI_ASSERT_IMPL(a_hit_den, dv_r[0] && dhit_r[0], dd_r[0] != '0)
  // a stalled pipe keeps its last divider stage
  `SI_ASSERT_NEXT(a_hold_tail, out_valid && out_stall, dv_r[QB] == $past(dv_r[QB]))

endmodule

### test/tb.sv
// Self-checking testbench for segment_intersection: directed and random segment pairs.
// Depends on segint_pkg and segment_intersection; an in-house predictor supplies expected results.
module tb;
  import segint_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  seg_pair_t  in_data;
  logic       out_valid;
  logic       out_stall;
  seg_cross_t out_data;

  // Idle and stall odds, in percent, for the current phase.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_count;
  seg_cross_t  pending_cross[$];

  segment_intersection uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Compute the crossing exactly. All products fit easily in 80 bits.
  function automatic seg_cross_t cross_of(seg_pair_t p);
    logic signed [79:0] ax, ay, dax, day, dbx, dby, ox, oy;
    logic signed [79:0] den, sn, tn, qx, qy;
    logic               s_ok, t_ok;
    seg_cross_t         r;
    ax  = 80'(p.a_start_x);
    ay  = 80'(p.a_start_y);
    dax = 80'(p.a_end_x) - ax;
    day = 80'(p.a_end_y) - ay;
    dbx = 80'(p.b_end_x) - 80'(p.b_start_x);
    dby = 80'(p.b_end_y) - 80'(p.b_start_y);
    ox  = ax - 80'(p.b_start_x);
    oy  = ay - 80'(p.b_start_y);
    den = dax * dby - dbx * day;
    sn  = dax * oy - day * ox;
    tn  = dbx * oy - dby * ox;
    r = '0;
    if (den != 0) begin
      if (den < 0) begin
        s_ok = (sn >= den) && (sn <= 0);
        t_ok = (tn >= den) && (tn <= 0);
      end else begin
        s_ok = (sn >= 0) && (sn <= den);
        t_ok = (tn >= 0) && (tn <= den);
      end
      if (s_ok && t_ok) begin
        // SystemVerilog signed division truncates toward zero.
        qx = (tn * dax) / den;
        qy = (tn * day) / den;
        r.hit     = 1'b1;
        r.cross_x = COORD_WIDTH'(ax + qx);
        r.cross_y = COORD_WIDTH'(ay + qy);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("tb: mismatch %s got %0h want %0h", what, got, want);
    mismatch_count++;
  endtask

  // Send one pair: idle at random, then hold valid until the transfer.
  // Valid stays high afterwards; a later idle or a drain drops it.
  task automatic send_pair(input seg_pair_t p);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_cross.push_back(cross_of(p));
  endtask

  // Randomize the receiver stall each cycle.
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    seg_cross_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cross.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_data.cross_x), 32'd0);
      end else begin
        want = pending_cross.pop_front();
        if (out_data.hit !== want.hit)
          report_mismatch("hit", 32'(out_data.hit), 32'(want.hit));
        if (out_data.cross_x !== want.cross_x)
          report_mismatch("cross_x", 32'(out_data.cross_x), 32'(want.cross_x));
        if (out_data.cross_y !== want.cross_y)
          report_mismatch("cross_y", 32'(out_data.cross_y), 32'(want.cross_y));
      end
    end
  end

  function automatic seg_pair_t pair_of(int ax, int ay, int ex, int ey,
                                        int bx, int by, int fx, int fy);
    seg_pair_t p;
    p.a_start_x = COORD_WIDTH'(ax); p.a_start_y = COORD_WIDTH'(ay);
    p.a_end_x   = COORD_WIDTH'(ex); p.a_end_y   = COORD_WIDTH'(ey);
    p.b_start_x = COORD_WIDTH'(bx); p.b_start_y = COORD_WIDTH'(by);
    p.b_end_x   = COORD_WIDTH'(fx); p.b_end_y   = COORD_WIDTH'(fy);
    return p;
  endfunction

  // Random coordinate: full range, or clustered near a center for likely hits.
  function automatic int rand_coord(input bit wide, input int center);
    if (wide) return int'($signed(16'($urandom)));
    return center + $signed(32'($urandom_range(0, 1023))) - 512;
  endfunction

  // Drop valid and hold until every expected result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_cross.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    // Plain crossing of two diagonals.
    send_pair(pair_of(0, 0, 256, 256, 0, 256, 256, 0));
    // Crossing at the endpoints of both segments.
    send_pair(pair_of(0, 0, 256, 0, 256, 0, 256, 256));
    send_pair(pair_of(0, 0, 256, 0, 0, 0, 0, -256));
    // Parallel, collinear overlapping, and zero-length segments.
    send_pair(pair_of(0, 0, 256, 0, 0, 256, 256, 256));
    send_pair(pair_of(0, 0, 512, 0, 256, 0, 768, 0));
    send_pair(pair_of(100, 100, 100, 100, 0, 0, 256, 256));
    send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
    // Lines cross outside the segments: a miss.
    send_pair(pair_of(0, 0, 256, 0, 512, -256, 512, 256));
    // Extremes of the coordinate range.
    send_pair(pair_of(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(pair_of(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
    send_pair(pair_of(-32768, 0, 32767, 0, 0, -32768, 1, 32767));
    send_pair(pair_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pair(pair_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    // Truncation toward zero on negative quotients.
    send_pair(pair_of(3, 7, -5, -9, -7, 1, 6, -4));
    send_pair(pair_of(-1, -1, 2, 3, 1, -2, -3, 4));
  endtask

  task automatic test_random(input int count);
    int        c, cx, cy;
    bit        wide;
    seg_pair_t p;
    for (int i = 0; i < count; i++) begin
      wide = ($urandom_range(3) == 0);
      cx = $signed(16'($urandom)) / 2;
      cy = $signed(16'($urandom)) / 2;
      c  = $urandom_range(9);
      p = pair_of(rand_coord(wide, cx), rand_coord(wide, cy),
                  rand_coord(wide, cx), rand_coord(wide, cy),
                  rand_coord(wide, cx), rand_coord(wide, cy),
                  rand_coord(wide, cx), rand_coord(wide, cy));
      // Force parallel or degenerate geometry now and then.
      if (c == 0) begin
        p.b_end_x = p.b_start_x + (p.a_end_x - p.a_start_x);
        p.b_end_y = p.b_start_y + (p.a_end_y - p.a_start_y);
      end else if (c == 1) begin
        p.a_end_x = p.a_start_x;
        p.a_end_y = p.a_start_y;
      end
      send_pair(p);
    end
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int count);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    test_random(count);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    run_phase(0, 0, 125);
    // Hold off until the pipe has drained before the next phase.
    wait_drained();
    run_phase(67, 0, 125);
    run_phase(0, 67, 125);
    run_phase(30, 30, 125);
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
